// File: hdl/pic_pkg.sv
// Package for the platform interrupt controller: default sizes, bus and
// request decode codes, and the request/result payload structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    localparam int NUM_SOURCES_DEF   = 64;
    localparam int PRIORITY_BITS_DEF = 5;

    // action codes
    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_REQUEST = 2'd2;

    // region codes
    localparam logic [2:0] RGN_PRIORITY  = 3'd0;
    localparam logic [2:0] RGN_PENDING   = 3'd1;
    localparam logic [2:0] RGN_ENABLE    = 3'd2;
    localparam logic [2:0] RGN_THRESHOLD = 3'd3;
    localparam logic [2:0] RGN_CLAIM     = 3'd4;

    // decoded operation carried through the scan
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PRIO_RD,
        OP_PRIO_WR,
        OP_PEND_RD,
        OP_EN_RD,
        OP_EN_WR,
        OP_THR_RD,
        OP_THR_WR,
        OP_CLAIM,
        OP_COMPLETE,
        OP_REQUEST
    } op_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  region;
        logic [5:0]  index;
        logic [31:0] write_data;
        logic [5:0]  source_id;
    } pic_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_out;
        logic        access_error;
    } pic_rsp_t;

endpackage

`default_nettype wire

// File: hdl/pic_ram.sv
// Per-source state memory: one write port, one read port, registered read.
// Depends on pic_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module pic_ram
    import pic_pkg::*;
#(
    parameter int WIDTH = PRIORITY_BITS_DEF + 3,
    parameter int DEPTH = NUM_SOURCES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/platform_interrupt_controller.sv
// Single-context interrupt controller. Every request sweeps the source memory once;
// a claim that finds a source then adds a fix-up write before the result is loaded.
// A new request waits until the previous result is loaded; a result stall holds it off.
// After reset a clearing pass zeroes the source memory; no request is taken meanwhile.
// Depends on pic_pkg and pic_ram.
`timescale 1ns / 1ps
`default_nettype none

module platform_interrupt_controller
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES   = NUM_SOURCES_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire pic_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output pic_rsp_t      rsp
);

    // Source memory entry: {priority, pending, enable, in_service}.
    // Source 0 is only ever written back unchanged, so it reads as zero.
    localparam int SRC_W     = $clog2(NUM_SOURCES);
    localparam int EW        = PRIORITY_BITS + 3;
    localparam int NUM_WORDS = (NUM_SOURCES + 31) / 32;
    localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = '1;
    localparam logic [SRC_W-1:0]         LAST_SRC = SRC_W'(NUM_SOURCES - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_FIX   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [SRC_W-1:0]         rd_addr_reg, rd_addr_next;
    logic                     issue_reg, issue_next;
    logic                     proc_valid_reg, proc_valid_next;
    logic [SRC_W-1:0]         proc_addr_reg, proc_addr_next;
    op_t                      op_reg, op_next;
    logic                     err_reg, err_next;
    logic [PRIORITY_BITS-1:0] threshold_reg, threshold_next;
    logic                     best_found_reg, best_found_next;
    logic                     second_found_reg, second_found_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    // payload registers, no reset
    logic [5:0]               index_reg, index_next;
    logic [31:0]              data_reg, data_next;
    logic [5:0]               sid_reg, sid_next;
    logic [31:0]              rd_reg, rd_next;
    logic [SRC_W-1:0]         best_id_reg, best_id_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;
    logic [PRIORITY_BITS-1:0] second_prio_reg, second_prio_next;
    pic_rsp_t                 rsp_reg, rsp_next;

    // memory ports
    logic                     ram_we;
    logic [SRC_W-1:0]         ram_waddr;
    logic [EW-1:0]            ram_wdata;
    logic [EW-1:0]            ram_rdata;

    pic_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SOURCES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Request decode. Range faults are found here; the sweep then only
    // modifies entries of a legal target.
    // ------------------------------------------------------------------
    logic req_accept;
    logic idx_src_ok, word_ok, data_src_ok, sid_ok, is_wr;
    op_t  dec_op;
    logic dec_err;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;

    assign idx_src_ok  = (req.index != 6'd0) && (32'(req.index) < 32'(NUM_SOURCES));
    assign word_ok     = 32'(req.index) < 32'(NUM_WORDS);
    assign data_src_ok = (req.write_data != 32'd0) && (req.write_data < 32'(NUM_SOURCES));
    assign sid_ok      = (req.source_id != 6'd0) && (32'(req.source_id) < 32'(NUM_SOURCES));
    assign is_wr       = (req.action == ACT_WRITE);

    always_comb
    begin
        dec_op  = OP_NONE;
        dec_err = 1'b0;
        unique case (req.action)
            ACT_READ, ACT_WRITE:
            begin
                unique case (req.region)
                    RGN_PRIORITY:
                    begin
                        if (!idx_src_ok)
                            dec_err = 1'b1;
                        else
                            dec_op = is_wr ? OP_PRIO_WR : OP_PRIO_RD;
                    end
                    RGN_PENDING:
                    begin
                        // pending word is read-only: writes do nothing
                        if (!word_ok)
                            dec_err = 1'b1;
                        else if (!is_wr)
                            dec_op = OP_PEND_RD;
                    end
                    RGN_ENABLE:
                    begin
                        if (!word_ok)
                            dec_err = 1'b1;
                        else
                            dec_op = is_wr ? OP_EN_WR : OP_EN_RD;
                    end
                    RGN_THRESHOLD:
                    begin
                        dec_op = is_wr ? OP_THR_WR : OP_THR_RD;
                    end
                    RGN_CLAIM:
                    begin
                        if (!is_wr)
                            dec_op = OP_CLAIM;
                        else if (!data_src_ok)
                            dec_err = 1'b1;
                        else
                            dec_op = OP_COMPLETE;
                    end
                    default:
                    begin
                        dec_err = 1'b1;
                    end
                endcase
            end
            ACT_REQUEST:
            begin
                if (!sid_ok)
                    dec_err = 1'b1;
                else
                    dec_op = OP_REQUEST;
            end
            default:
            begin
                dec_err = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sweep datapath. Read of entry k+1 is issued while entry k is
    // modified and written back, so the read and write addresses never
    // coincide inside a sweep; the claim fix-up write lands before the
    // next request's first read.
    // ------------------------------------------------------------------
    logic [PRIORITY_BITS-1:0] cur_prio, mod_prio;
    logic                     cur_pend, cur_en, cur_isv;
    logic                     mod_pend, mod_en, mod_isv;
    logic                     word_hit, addr_nz, qual;
    logic [4:0]               bit_pos;

    assign cur_prio = ram_rdata[EW-1:3];
    assign cur_pend = ram_rdata[2];
    assign cur_en   = ram_rdata[1];
    assign cur_isv  = ram_rdata[0];

    assign word_hit = (32'(proc_addr_reg) >> 5) == 32'(index_reg);
    assign bit_pos  = 5'(32'(proc_addr_reg));
    assign addr_nz  = (proc_addr_reg != '0);

    always_comb
    begin
        mod_prio = cur_prio;
        mod_pend = cur_pend;
        mod_en   = cur_en;
        mod_isv  = cur_isv;
        unique case (op_reg)
            OP_PRIO_WR:
            begin
                if (32'(proc_addr_reg) == 32'(index_reg))
                    mod_prio = data_reg[PRIORITY_BITS-1:0];
            end
            OP_EN_WR:
            begin
                if (word_hit && addr_nz)
                    mod_en = data_reg[bit_pos];
            end
            OP_COMPLETE:
            begin
                // complete of a disabled source is ignored
                if ((32'(proc_addr_reg) == data_reg) && cur_en)
                    mod_isv = 1'b0;
            end
            OP_REQUEST:
            begin
                // a source in service drops further requests
                if ((32'(proc_addr_reg) == 32'(sid_reg)) && !cur_isv)
                    mod_pend = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign qual = addr_nz && mod_pend && mod_en && (mod_prio > threshold_reg);

    // ------------------------------------------------------------------
    // Control and next-state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        rd_addr_next      = rd_addr_reg;
        issue_next        = issue_reg;
        proc_valid_next   = 1'b0;
        proc_addr_next    = proc_addr_reg;
        op_next           = op_reg;
        err_next          = err_reg;
        threshold_next    = threshold_reg;
        best_found_next   = best_found_reg;
        best_id_next      = best_id_reg;
        best_prio_next    = best_prio_reg;
        second_found_next = second_found_reg;
        second_prio_next  = second_prio_reg;
        index_next        = index_reg;
        data_next         = data_reg;
        sid_next          = sid_reg;
        rd_next           = rd_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        ram_we            = 1'b0;
        ram_waddr         = proc_addr_reg;
        ram_wdata         = {mod_prio, mod_pend, mod_en, mod_isv};

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = rd_addr_reg;
                ram_wdata = '0;
                if (rd_addr_reg == LAST_SRC)
                begin
                    rd_addr_next = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + SRC_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next        = ST_SCAN;
                    rd_addr_next      = '0;
                    issue_next        = 1'b1;
                    op_next           = dec_op;
                    err_next          = dec_err;
                    index_next        = req.index;
                    data_next         = req.write_data;
                    sid_next          = req.source_id;
                    best_found_next   = 1'b0;
                    best_id_next      = '0;
                    best_prio_next    = '0;
                    second_found_next = 1'b0;
                    second_prio_next  = '0;
                    rd_next           = (dec_op == OP_THR_RD) ? 32'(threshold_reg) : 32'd0;
                    // threshold takes effect before the sweep judges irq
                    if (dec_op == OP_THR_WR)
                    begin
                        if (req.write_data > 32'(PRIO_MAX))
                            threshold_next = PRIO_MAX;
                        else
                            threshold_next = req.write_data[PRIORITY_BITS-1:0];
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    proc_valid_next = 1'b1;
                    proc_addr_next  = rd_addr_reg;
                    if (rd_addr_reg == LAST_SRC)
                    begin
                        issue_next   = 1'b0;
                        rd_addr_next = '0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + SRC_W'(1);
                    end
                end
                if (proc_valid_reg)
                begin
                    ram_we = 1'b1;
                    // best and runner-up; strict compare keeps lowest ID on ties
                    if (qual)
                    begin
                        if (mod_prio > best_prio_reg)
                        begin
                            second_found_next = best_found_reg;
                            second_prio_next  = best_prio_reg;
                            best_found_next   = 1'b1;
                            best_id_next      = proc_addr_reg;
                            best_prio_next    = mod_prio;
                        end
                        else if (mod_prio > second_prio_reg)
                        begin
                            second_found_next = 1'b1;
                            second_prio_next  = mod_prio;
                        end
                    end
                    if (((op_reg == OP_PEND_RD) || (op_reg == OP_EN_RD)) && word_hit && addr_nz)
                    begin
                        rd_next[bit_pos] = (op_reg == OP_PEND_RD) ? cur_pend : cur_en;
                    end
                    if ((op_reg == OP_PRIO_RD) && (32'(proc_addr_reg) == 32'(index_reg)))
                    begin
                        rd_next = 32'(cur_prio);
                    end
                    if (proc_addr_reg == LAST_SRC)
                    begin
                        if ((op_reg == OP_CLAIM) && best_found_next)
                            state_next = ST_FIX;
                        else
                            state_next = ST_DONE;
                    end
                end
            end
            ST_FIX:
            begin
                // claimed source: clear pending, mark in service
                ram_we     = 1'b1;
                ram_waddr  = best_id_reg;
                ram_wdata  = {best_prio_reg, 1'b0, 1'b1, 1'b1};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.access_error = err_reg;
                    if (op_reg == OP_CLAIM)
                    begin
                        rsp_next.read_data = best_found_reg ? 32'(best_id_reg) : 32'd0;
                        rsp_next.irq_out   = best_found_reg ? second_found_reg : 1'b0;
                    end
                    else
                    begin
                        rsp_next.read_data = rd_reg;
                        rsp_next.irq_out   = best_found_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            rd_addr_reg      <= '0;
            issue_reg        <= 1'b0;
            proc_valid_reg   <= 1'b0;
            proc_addr_reg    <= '0;
            op_reg           <= OP_NONE;
            err_reg          <= 1'b0;
            threshold_reg    <= '0;
            best_found_reg   <= 1'b0;
            second_found_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_addr_reg      <= rd_addr_next;
            issue_reg        <= issue_next;
            proc_valid_reg   <= proc_valid_next;
            proc_addr_reg    <= proc_addr_next;
            op_reg           <= op_next;
            err_reg          <= err_next;
            threshold_reg    <= threshold_next;
            best_found_reg   <= best_found_next;
            second_found_reg <= second_found_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg       <= index_next;
        data_reg        <= data_next;
        sid_reg         <= sid_next;
        rd_reg          <= rd_next;
        best_id_reg     <= best_id_next;
        best_prio_reg   <= best_prio_next;
        second_prio_reg <= second_prio_next;
        rsp_reg         <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (issue_reg && proc_valid_reg) |-> (proc_addr_reg != rd_addr_reg))
        else $error("sweep read and write-back hit the same entry");

    a_fix_is_claim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> (best_found_reg && (op_reg == OP_CLAIM)))
        else $error("fix-up write without a claimed source");

    a_runner_up: assert property (@(posedge clk) disable iff (!rst_n)
        second_found_reg |-> best_found_reg)
        else $error("runner-up found without a best source");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("memory write while idle");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall))
            |=> (rsp_valid && (state_reg == ST_IDLE)))
        else $error("finished request did not reach the result register");

endmodule

`default_nettype wire

// File: test/pic_checker.sv
// Scoreboard for the platform interrupt controller: watches both channels,
// keeps its own copy of the controller state, and compares every result.
// Depends on pic_pkg.
`timescale 1ns / 1ps

module pic_checker
    import pic_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire logic     req_stall,
    input  wire pic_req_t req,
    input  wire logic     rsp_valid,
    input  wire logic     rsp_stall,
    input  wire pic_rsp_t rsp,
    output int            fail_count,
    output int            outstanding,
    output int            checked_count
);

    localparam int NSRC   = NUM_SOURCES_DEF;
    localparam int PBITS  = PRIORITY_BITS_DEF;
    localparam int NWORDS = (NSRC + 31) / 32;
    localparam int SW     = $clog2(NSRC);
    localparam logic [PBITS-1:0] PRIO_TOP = '1;

    logic [PBITS-1:0] prio_mem [NSRC];
    logic [NSRC-1:0]  pend_vec;
    logic [NSRC-1:0]  en_vec;
    logic [NSRC-1:0]  busy_vec;
    logic [PBITS-1:0] thr_reg;

    pic_rsp_t awaited_rsp_q [$];

    // winning source: highest priority above threshold, lowest id on ties
    function automatic int top_source();
        int best;
        logic [PBITS-1:0] best_p;
        best   = 0;
        best_p = '0;
        for (int s = 1; s < NSRC; s++) begin
            if (pend_vec[s] && en_vec[s] && prio_mem[s] > thr_reg && prio_mem[s] > best_p) begin
                best   = s;
                best_p = prio_mem[s];
            end
        end
        return best;
    endfunction

    function automatic logic [31:0] word_bits(logic [NSRC-1:0] v, int w);
        logic [31:0] r;
        r = '0;
        for (int s = 1; s < NSRC; s++)
            if (s / 32 == w && v[s])
                r[s % 32] = 1'b1;
        return r;
    endfunction

    // apply one request to the shadow state, return the result it yields
    task automatic serve_request(input pic_req_t r, output pic_rsp_t o);
        logic [31:0] rd;
        logic        err;
        logic        wr;
        int          idx;
        int          sel;
        rd  = '0;
        err = 1'b0;
        wr  = (r.action == ACT_WRITE);
        idx = r.index;
        case (r.action)
            ACT_READ, ACT_WRITE: begin
                case (r.region)
                    RGN_PRIORITY: begin
                        if (idx == 0 || idx >= NSRC)
                            err = 1'b1;
                        else if (wr)
                            prio_mem[idx] = r.write_data[PBITS-1:0];
                        else
                            rd = 32'(prio_mem[idx]);
                    end
                    RGN_PENDING: begin
                        // pending word is read-only: writes fall through silently
                        if (idx >= NWORDS)
                            err = 1'b1;
                        else if (!wr)
                            rd = word_bits(pend_vec, idx);
                    end
                    RGN_ENABLE: begin
                        if (idx >= NWORDS)
                            err = 1'b1;
                        else if (wr) begin
                            for (int s = 1; s < NSRC; s++)
                                if (s / 32 == idx)
                                    en_vec[s] = r.write_data[s % 32];
                        end
                        else
                            rd = word_bits(en_vec, idx);
                    end
                    RGN_THRESHOLD: begin
                        if (wr)
                            thr_reg = (r.write_data > 32'(PRIO_TOP)) ? PRIO_TOP
                                                                     : r.write_data[PBITS-1:0];
                        else
                            rd = 32'(thr_reg);
                    end
                    RGN_CLAIM: begin
                        if (wr) begin
                            if (r.write_data == 0 || r.write_data >= NSRC)
                                err = 1'b1;
                            else if (en_vec[r.write_data[SW-1:0]])
                                busy_vec[r.write_data[SW-1:0]] = 1'b0;
                        end
                        else begin
                            sel = top_source();
                            if (sel != 0) begin
                                pend_vec[sel] = 1'b0;
                                busy_vec[sel] = 1'b1;
                            end
                            rd = 32'(sel);
                        end
                    end
                    default: err = 1'b1;
                endcase
            end
            ACT_REQUEST: begin
                if (r.source_id == 0 || r.source_id >= NSRC)
                    err = 1'b1;
                else if (!busy_vec[r.source_id])
                    pend_vec[r.source_id] = 1'b1;
            end
            default: err = 1'b1;
        endcase
        o.read_data    = rd;
        o.irq_out      = (top_source() != 0);
        o.access_error = err;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        pic_rsp_t want;
        pic_rsp_t made;
        if (!rst_n) begin
            for (int s = 0; s < NSRC; s++)
                prio_mem[s] = '0;
            pend_vec      = '0;
            en_vec        = '0;
            busy_vec      = '0;
            thr_reg       = '0;
            awaited_rsp_q.delete();
            fail_count    = 0;
            outstanding   = 0;
            checked_count = 0;
        end
        else begin
            // result first: a request taken at this edge cannot answer at this edge
            if (rsp_valid && !rsp_stall) begin
                if (awaited_rsp_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, rsp);
                    fail_count++;
                end
                else begin
                    want = awaited_rsp_q.pop_front();
                    checked_count++;
                    if (rsp.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h got %h",
                                 $time, want.read_data, rsp.read_data);
                        fail_count++;
                    end
                    if (rsp.irq_out !== want.irq_out) begin
                        $display("%0t: irq_out expected %b got %b",
                                 $time, want.irq_out, rsp.irq_out);
                        fail_count++;
                    end
                    if (rsp.access_error !== want.access_error) begin
                        $display("%0t: access_error expected %b got %b",
                                 $time, want.access_error, rsp.access_error);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall) begin
                serve_request(req, made);
                awaited_rsp_q.push_back(made);
            end
            outstanding = awaited_rsp_q.size();
        end
    end

endmodule

// File: test/tb_top.sv
// Testbench top for the platform interrupt controller: clock, reset, request
// stimulus and result-side stall; pic_checker does prediction and compare.
// Depends on pic_pkg, platform_interrupt_controller and pic_checker.
`timescale 1ns / 1ps

module tb_top;
    import pic_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;   // undecoded action
    localparam logic [2:0] RGN_SPARE_LO = 3'd5;   // first undecoded region
    localparam logic [2:0] RGN_SPARE_HI = 3'd7;
    localparam int         RANDOM_REQS  = 600;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    pic_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    pic_rsp_t rsp;

    int fail_count;
    int outstanding;
    int checked_count;
    int sent_count = 0;
    bit idle_en    = 1'b1;

    platform_interrupt_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    pic_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result-side back-pressure, same idle rate as the sender
    always @(negedge clk)
    begin
        rsp_stall <= idle_en && ($urandom_range(99) < 13);
    end

    // hard stop; a correct run ends far sooner
    initial
    begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic pic_req_t mk(logic [1:0] a, logic [2:0] g, logic [5:0] i,
                                    logic [31:0] d, logic [5:0] s);
        pic_req_t r;
        r.action     = a;
        r.region     = g;
        r.index      = i;
        r.write_data = d;
        r.source_id  = s;
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(input pic_req_t r);
        while (idle_en && $urandom_range(99) < 13)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    // sender holds off until every result is back
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // sources mostly from a small pool so claims and completes meet again
    function automatic logic [5:0] pick_src();
        if ($urandom_range(9) == 0)
            return 6'($urandom_range(63));
        return 6'($urandom_range(8, 1));
    endfunction

    function automatic pic_req_t random_req();
        pic_req_t r;
        int       k;
        // unused fields keep random content
        r = mk(2'($urandom), 3'($urandom), 6'($urandom), $urandom, 6'($urandom));
        k = $urandom_range(99);
        if (k < 25)
        begin
            r.action    = ACT_REQUEST;
            r.source_id = pick_src();
        end
        else if (k < 45)
        begin
            r.action = ACT_READ;
            r.region = RGN_CLAIM;
        end
        else if (k < 60)
        begin
            r.action     = ACT_WRITE;
            r.region     = RGN_CLAIM;
            r.write_data = ($urandom_range(19) == 0) ? $urandom : 32'(pick_src());
        end
        else if (k < 72)
        begin
            r.action = ACT_WRITE;
            r.region = RGN_PRIORITY;
            r.index  = pick_src();
        end
        else if (k < 78)
        begin
            r.action = ACT_WRITE;
            r.region = RGN_ENABLE;
            if ($urandom_range(3) == 0)
                r.index = 6'($urandom_range(63));
            else
            begin
                r.index      = 6'd0;
                r.write_data = $urandom | 32'h0000_01fe;
            end
        end
        else if (k < 82)
        begin
            r.action = ACT_WRITE;
            r.region = RGN_THRESHOLD;
            if ($urandom_range(4) != 0)
                r.write_data = $urandom_range(6);
        end
        else if (k < 93)
        begin
            r.action = ACT_READ;
            r.region = 3'($urandom_range(3));
            if ($urandom_range(3) != 0)
                r.index = (r.region == RGN_PRIORITY) ? pick_src() : 6'($urandom_range(1));
        end
        else
        begin
            // noise: anything the fields allow, including undecoded codes
            r.action = 2'($urandom_range(3));
            r.region = 3'($urandom_range(7));
        end
        return r;
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: truncation, saturation, faults, claim order, in-service drop
        send(mk(ACT_WRITE, RGN_PRIORITY,  6'd1,  32'hffff_ffff, 6'd0));
        send(mk(ACT_READ,  RGN_PRIORITY,  6'd1,  32'h0,         6'd0));
        send(mk(ACT_WRITE, RGN_PRIORITY,  6'd0,  32'h5,         6'd0));
        send(mk(ACT_WRITE, RGN_PRIORITY,  6'd63, 32'h7,         6'd0));
        send(mk(ACT_WRITE, RGN_ENABLE,    6'd0,  32'hffff_ffff, 6'd0));
        send(mk(ACT_WRITE, RGN_ENABLE,    6'd1,  32'hffff_ffff, 6'd0));
        send(mk(ACT_READ,  RGN_ENABLE,    6'd0,  32'h0,         6'd0));
        send(mk(ACT_READ,  RGN_ENABLE,    6'd2,  32'h0,         6'd0));
        send(mk(ACT_WRITE, RGN_THRESHOLD, 6'd0,  32'hffff_ffff, 6'd0));
        send(mk(ACT_READ,  RGN_THRESHOLD, 6'd0,  32'h0,         6'd0));
        send(mk(ACT_WRITE, RGN_THRESHOLD, 6'd0,  32'h0,         6'd0));
        send(mk(ACT_REQUEST, RGN_PRIORITY, 6'd0, 32'h0,         6'd0));
        send(mk(ACT_REQUEST, RGN_PRIORITY, 6'd0, 32'h0,         6'd1));
        send(mk(ACT_REQUEST, RGN_PRIORITY, 6'd0, 32'h0,         6'd63));
        send(mk(ACT_READ,  RGN_PENDING,   6'd1,  32'h0,         6'd0));
        send(mk(ACT_WRITE, RGN_PENDING,   6'd0,  32'hffff_ffff, 6'd0));
        send(mk(ACT_READ,  RGN_PENDING,   6'd63, 32'h0,         6'd0));
        send(mk(ACT_READ,  RGN_CLAIM,     6'd0,  32'h0,         6'd0));
        send(mk(ACT_REQUEST, RGN_PRIORITY, 6'd0, 32'h0,         6'd1));
        send(mk(ACT_READ,  RGN_CLAIM,     6'd0,  32'h0,         6'd0));
        send(mk(ACT_READ,  RGN_CLAIM,     6'd0,  32'h0,         6'd0));
        send(mk(ACT_WRITE, RGN_CLAIM,     6'd0,  32'h0,         6'd0));
        send(mk(ACT_WRITE, RGN_CLAIM,     6'd0,  32'd64,        6'd0));
        send(mk(ACT_WRITE, RGN_ENABLE,    6'd1,  32'h0,         6'd0));
        send(mk(ACT_WRITE, RGN_CLAIM,     6'd0,  32'd63,        6'd0));
        send(mk(ACT_WRITE, RGN_CLAIM,     6'd0,  32'd1,         6'd0));
        send(mk(ACT_REQUEST, RGN_PRIORITY, 6'd0, 32'h0,         6'd1));
        send(mk(ACT_READ,  RGN_SPARE_LO,  6'd0,  32'h0,         6'd0));
        send(mk(ACT_WRITE, RGN_SPARE_HI,  6'd0,  32'h0,         6'd0));
        send(mk(ACT_RESERVED, RGN_CLAIM,  6'd0,  32'h0,         6'd0));
        drain();

        // random traffic; a quiet stretch in the middle with no idling at all
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == 200)
                idle_en = 1'b0;
            if (n == 350)
                idle_en = 1'b1;
            if (n == 450)
                drain();
            send(random_req());
        end

        drain();
        repeat (100) @(negedge clk);

        $display("Checked %0d results from %0d requests: priority, pending, enable,",
                 checked_count, sent_count);
        $display("threshold, claim/complete and source requests, faults and stalls included.");
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/pic_pkg.sv
hdl/pic_ram.sv
hdl/platform_interrupt_controller.sv
test/pic_checker.sv
test/tb_top.sv
